// File: rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Disk geometry.
  localparam int CYLINDERS         = 8;
  localparam int BITS_PER_CYLINDER = 8;
  localparam int RECORDS_PER_TRACK = 4;
  localparam int MAX_RESULTS       = 64;

  localparam int TOTAL_BLOCKS = CYLINDERS * BITS_PER_CYLINDER;
  localparam int TRACKS       = (BITS_PER_CYLINDER + RECORDS_PER_TRACK - 1) / RECORDS_PER_TRACK;

  // Counter widths for the bitmap walk.
  localparam int CYL_W  = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
  localparam int BIT_W  = $clog2(BITS_PER_CYLINDER);
  localparam int REC_W  = (RECORDS_PER_TRACK > 1) ? $clog2(RECORDS_PER_TRACK) : 1;
  localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int FREE_W = $clog2(TOTAL_BLOCKS + 1);
  localparam int POS_W  = $clog2(3 * RECORDS_PER_TRACK + 4);

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_FREED   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADADDR = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [6:0] block_count;
    logic [3:0] cylinder;
    logic [1:0] track;
    logic [1:0] record;
  } bba_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       has_block;
    logic [2:0] out_cylinder;
    logic       out_track;
    logic [1:0] out_record;
    logic       last;
  } bba_out_t;

  // Control from the sequencer to the bitmap shift register.
  typedef struct packed {
    logic step;
    logic head_next;
  } bba_map_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bba_bitmap_sr.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular shift register holding the used-block bitmap. The bit at index 0
// is the block under the walk position; each step rotates by one bit and
// writes back the (possibly updated) head bit at the top.
module bba_bitmap_sr (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire bba_pkg::bba_map_ctl_t ctl,
  output logic                       head
);
  import bba_pkg::*;

  logic [TOTAL_BLOCKS-1:0] map_r;
  logic [TOTAL_BLOCKS-1:0] map_nxt;

  // Rotate one position per step, replacing the head bit on its way around.
  always_comb begin
    map_nxt = map_r;
    if (ctl.step) begin
      map_nxt = {ctl.head_next, map_r[TOTAL_BLOCKS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else begin
      map_r <= map_nxt;
    end
  end

  assign head = map_r[0];

endmodule

`default_nettype wire

// File: rtl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Word      Handshake
// in_      input      bba_in_t  in_valid / in_ready
// out_     output     bba_out_t out_valid / out_ready
//
// An allocate word walks the whole bitmap once, one bit per cycle through a
// rotating shift register while no claim waits on a stalled output: all
// CYLINDERS * BITS_PER_CYLINDER (64) bits; a free word walks it too, then replies.
// Zero-block requests, refused requests and bad addresses reply without a walk.
// A stalled output holds the walk on the next free bit it has to claim.
// Reset (rst_n, synchronous) marks every block free; no clearing pass.
module bitmap_block_allocator (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire bba_pkg::bba_in_t   in_word,
  output logic                    out_valid,
  input  wire                     out_ready,
  output bba_pkg::bba_out_t       out_word
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_REPLY = 3'b100
  } state_t;

  localparam logic [CYL_W-1:0] CYL_LAST = CYL_W'(CYLINDERS - 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BITS_PER_CYLINDER - 1);
  localparam logic [REC_W-1:0] REC_LAST = REC_W'(RECORDS_PER_TRACK - 1);

  state_t            state_r, state_nxt;
  logic              mode_free_r, mode_free_nxt;
  logic [6:0]        rem_r, rem_nxt;
  logic [FREE_W-1:0] free_total_r, free_total_nxt;
  logic [CYL_W-1:0]  cyl_r, cyl_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [REC_W-1:0]  rec_r, rec_nxt;
  logic [TRK_W-1:0]  trk_r, trk_nxt;
  logic [CYL_W-1:0]  tgt_cyl_r, tgt_cyl_nxt;
  logic [BIT_W-1:0]  tgt_bit_r, tgt_bit_nxt;
  logic [1:0]        reply_st_r, reply_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  bba_out_t          out_word_r, out_word_nxt;

  bba_map_ctl_t      map_ctl;
  logic              head;
  logic              can_load;
  logic              load;
  bba_out_t          load_word;
  logic              at_end;
  logic              at_target;
  logic              bad_addr;
  logic [POS_W-1:0]  free_pos;

  bba_bitmap_sr u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (map_ctl),
    .head  (head)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign can_load  = !out_valid_r || out_ready;
  assign at_end    = (cyl_r == CYL_LAST) && (bit_r == BIT_LAST);
  assign at_target = (cyl_r == tgt_cyl_r) && (bit_r == tgt_bit_r);

  // Bit index of the block named by a free request.
  assign free_pos = POS_W'(in_word.track) * POS_W'(RECORDS_PER_TRACK) + POS_W'(in_word.record);
  assign bad_addr = (int'(in_word.cylinder) > CYLINDERS - 1) ||
                    (int'(free_pos) > BITS_PER_CYLINDER - 1);

  // Sequencer: decode the request, walk the bitmap, emit the results.
  always_comb begin
    state_nxt         = state_r;
    mode_free_nxt     = mode_free_r;
    rem_nxt           = rem_r;
    free_total_nxt    = free_total_r;
    cyl_nxt           = cyl_r;
    bit_nxt           = bit_r;
    rec_nxt           = rec_r;
    trk_nxt           = trk_r;
    tgt_cyl_nxt       = tgt_cyl_r;
    tgt_bit_nxt       = tgt_bit_r;
    reply_st_nxt      = reply_st_r;
    map_ctl.step      = 1'b0;
    map_ctl.head_next = head;
    load              = 1'b0;
    load_word         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_word.kind == KIND_ALLOC) begin
            if (in_word.block_count == '0) begin
              reply_st_nxt = ST_ALLOC;
              state_nxt    = S_REPLY;
            end else if ((int'(in_word.block_count) > int'(free_total_r)) ||
                         (int'(in_word.block_count) > MAX_RESULTS)) begin
              reply_st_nxt = ST_NOSPACE;
              state_nxt    = S_REPLY;
            end else begin
              rem_nxt       = in_word.block_count;
              mode_free_nxt = 1'b0;
              state_nxt     = S_WALK;
            end
          end else begin
            if (bad_addr) begin
              reply_st_nxt = ST_BADADDR;
              state_nxt    = S_REPLY;
            end else begin
              tgt_cyl_nxt   = CYL_W'(in_word.cylinder);
              tgt_bit_nxt   = BIT_W'(free_pos);
              mode_free_nxt = 1'b1;
              state_nxt     = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        if (!mode_free_r && (rem_r != '0) && !head) begin
          // Free bit still wanted: claim it once the output slot is open.
          if (can_load) begin
            load                   = 1'b1;
            load_word.status       = ST_ALLOC;
            load_word.has_block    = 1'b1;
            load_word.out_cylinder = 3'(cyl_r);
            load_word.out_track    = 1'(trk_r);
            load_word.out_record   = 2'(rec_r);
            load_word.last         = (rem_r == 7'd1);
            map_ctl.head_next      = 1'b1;
            map_ctl.step           = 1'b1;
            rem_nxt                = rem_r - 7'd1;
            free_total_nxt         = free_total_r - FREE_W'(1);
          end
        end else if (mode_free_r && at_target) begin
          map_ctl.head_next = 1'b0;
          map_ctl.step      = 1'b1;
          if (head) begin
            free_total_nxt = free_total_r + FREE_W'(1);
          end
        end else begin
          map_ctl.step = 1'b1;
        end

        // Advance the walk position in step with the rotation.
        if (map_ctl.step) begin
          if (bit_r == BIT_LAST) begin
            bit_nxt = '0;
            rec_nxt = '0;
            trk_nxt = '0;
            cyl_nxt = at_end ? '0 : cyl_r + CYL_W'(1);
          end else begin
            bit_nxt = bit_r + BIT_W'(1);
            if (rec_r == REC_LAST) begin
              rec_nxt = '0;
              trk_nxt = trk_r + TRK_W'(1);
            end else begin
              rec_nxt = rec_r + REC_W'(1);
            end
          end
          if (at_end) begin
            if (mode_free_r) begin
              reply_st_nxt = ST_FREED;
              state_nxt    = S_REPLY;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      S_REPLY: begin
        if (can_load) begin
          load           = 1'b1;
          load_word      = '0;
          load_word.status = reply_st_r;
          load_word.last = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register separates the walk from the consumer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = load_word;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_free_r  <= 1'b0;
      rem_r        <= '0;
      free_total_r <= FREE_W'(TOTAL_BLOCKS);
      cyl_r        <= '0;
      bit_r        <= '0;
      rec_r        <= '0;
      trk_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_free_r  <= mode_free_nxt;
      rem_r        <= rem_nxt;
      free_total_r <= free_total_nxt;
      cyl_r        <= cyl_nxt;
      bit_r        <= bit_nxt;
      rec_r        <= rec_nxt;
      trk_r        <= trk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    tgt_cyl_r  <= tgt_cyl_nxt;
    tgt_bit_r  <= tgt_bit_nxt;
    reply_st_r <= reply_st_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// File: rtl/bba_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the allocator.
module bba_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire bba_pkg::bba_in_t   in_word,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire bba_pkg::bba_out_t  out_word
);
  import bba_pkg::*;

  // A word without a block carries a zero address.
  a_no_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.has_block) |->
      (out_word.out_cylinder == '0 && out_word.out_track == 1'b0 &&
       out_word.out_record == '0))
    else $error("no-block result carries an address");

  // Only allocation results carry a block.
  a_block_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.has_block) |-> (out_word.status == ST_ALLOC))
    else $error("block carried by a non-allocation result");

  // Freed, refused and bad-address results are single, final words.
  a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == ST_FREED || out_word.status == ST_NOSPACE ||
                   out_word.status == ST_BADADDR)) |->
      (out_word.last && !out_word.has_block))
    else $error("reply word is not a single final word");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");

  // A waiting request word holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_word)))
    else $error("waiting request word changed");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
